FILE: rtl/isort_pkg.sv
// Shared types and constants for the insertion sorter cell row.
`timescale 1ns / 1ps

package isort_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic  ins;   // insert value into the row
		logic  shd;   // shift the row down by one place (drain)
		data_t value; // value being inserted
	} cell_ctrl_t;

	// What a cell shows to its neighbours.
	typedef struct packed {
		logic  valid;
		logic  gt;    // held value is strictly greater than the inserted one
		data_t value;
	} cell_stat_t;

endpackage

FILE: rtl/isort_cell.sv
// One cell of the sorting row: holds a single value and its valid bit.
`timescale 1ns / 1ps

module isort_cell
	import isort_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  cell_stat_t left,
	input  cell_stat_t right,
	output cell_stat_t stat
);

	data_t val_q;
	logic  valid_q;
	logic  gt;
	logic  take;

	assign gt   = valid_q && (val_q > ctrl.value);
	// Take a value when ours moves up, or when this is the first empty slot.
	assign take = gt || (!valid_q && left.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins && take) begin
			valid_q <= 1'b1;
		end else if (ctrl.shd) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && take) begin
			val_q <= left.gt ? left.value : ctrl.value;
		end else if (ctrl.shd) begin
			val_q <= right.value;
		end
	end

	assign stat.valid = valid_q;
	assign stat.gt    = gt;
	assign stat.value = val_q;

endmodule

FILE: rtl/insertion_sorter.sv
// Insertion sorter: a row of cells kept in ascending order, drained on the last request.
// Latency: a request is inserted in the cycle it is accepted, or dropped if the row is full;
// after a request with tlast the first result is offered in the next cycle. Throughput: one
// request per cycle while filling, set by the one-compare-per-cell insertion; a set drains
// value by value through cell 0, during which no request is accepted. Reset (arst_n low)
// empties the row and clears the overflow flag; cell contents themselves are not reset.
`timescale 1ns / 1ps

module insertion_sorter
	import isort_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tlast,   // final_item
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic              m_tlast,   // last_out
	output logic              m_tuser    // [0] overflowed
);

	cell_ctrl_t            ctrl;
	cell_stat_t            stat  [CAPACITY];
	cell_stat_t            lnb   [CAPACITY];
	cell_stat_t            rnb   [CAPACITY];
	logic [CAPACITY-1:0]   valid_vec;
	logic                  drain_q;
	logic                  drop_q;
	logic                  in_acc;
	logic                  out_acc;
	logic                  full;

	assign full     = stat[CAPACITY-1].valid;
	assign s_tready = !drain_q;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = drain_q && stat[0].valid;
	assign out_acc  = m_tvalid && m_tready;
	assign m_tdata  = stat[0].value;
	assign m_tlast  = !stat[1].valid;
	assign m_tuser  = drop_q;

	assign ctrl.ins   = in_acc && !full;
	assign ctrl.shd   = out_acc;
	assign ctrl.value = s_tdata;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign lnb[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
			end else begin : g_mid
				assign lnb[i] = stat[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign rnb[i] = '{valid: 1'b0, gt: 1'b0, value: '0};
			end else begin : g_inner
				assign rnb[i] = stat[i+1];
			end
			assign valid_vec[i] = stat[i].valid;

			isort_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.left   (lnb[i]),
				.right  (rnb[i]),
				.stat   (stat[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			if (in_acc && s_tlast) begin
				drain_q <= 1'b1;
			end else if (out_acc && m_tlast) begin
				drain_q <= 1'b0;
			end
			// Remember a dropped request until the set has been emitted.
			if (in_acc && full) begin
				drop_q <= 1'b1;
			end else if (out_acc && m_tlast) begin
				drop_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request accepted while draining");

	a_empty_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tlast |=> !m_tvalid && !stat[0].valid && !drop_q)
		else $error("row not empty after last result");

	a_drain_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tlast |=> m_tvalid)
		else $error("no result after final request");

	a_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("valid cells not contiguous");
`endif

endmodule
